@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the hash engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sha1e_pkg.sv @@
// Package with the item types, constants and queue interface types of the SHA-1 engine.
`default_nettype none
package sha1e_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_item;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	localparam int QDepth = 32;
	localparam int QAw = 5;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0]  PadByte = 8'h80;

	typedef struct packed {
		logic            we;
		logic [QAw-1:0]  addr;
		logic [31:0]     data;
		logic            block_done;
		logic            final_blk;
	} qwr_t;

	typedef struct packed {
		logic            start;
		logic            release_blk;
		logic [QAw-1:0]  rd_addr;
		logic            rd_slot;
	} qrd_t;

endpackage
`default_nettype wire

@@ hdl/sha1e_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sha1e_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/sha1e_front.sv @@
// Front part: takes message bytes, packs words, pads the message and fills the block queue.
`default_nettype none
module sha1e_front import sha1e_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t data,
	input  wire logic     space,
	output qwr_t          qwr
);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_PAD  = 2'b10
	} fstate_t;

	fstate_t     state_q;
	logic [5:0]  fill_q;
	logic [60:0] nbytes_q;
	logic [23:0] acc_q;
	logic        wslot_q;
	logic        pad_first_q;
	logic        len_ok_q;

	logic        accept;
	logic        put;
	logic [7:0]  put_byte;
	logic [63:0] bit_len;
	logic [63:0] len_shift;
	logic        len_phase;
	logic        final_put;

	assign full = (state_q != F_IDLE) || !space;
	assign accept = push && !full;
	assign bit_len = {nbytes_q, 3'b000};
	assign len_shift = bit_len << {fill_q[2:0], 3'b000};
	assign len_phase = !pad_first_q && len_ok_q && (fill_q >= 6'd56);
	assign final_put = (state_q == F_PAD) && put && len_phase && (fill_q == 6'd63);

	always_comb begin
		put = 1'b0;
		put_byte = data.data_byte;
		unique case (state_q)
			F_IDLE: begin
				put = accept && data.has_byte;
				put_byte = data.data_byte;
			end
			F_PAD: begin
				put = space;
				if (pad_first_q) begin
					put_byte = PadByte;
				end else if (len_phase) begin
					put_byte = len_shift[63:56];
				end else begin
					put_byte = 8'h00;
				end
			end
			default: begin
				put = 1'b0;
			end
		endcase
	end

	always_comb begin
		qwr.we = put && (fill_q[1:0] == 2'b11);
		qwr.addr = {wslot_q, fill_q[5:2]};
		qwr.data = {acc_q, put_byte};
		qwr.block_done = put && (fill_q == 6'd63);
		qwr.final_blk = final_put;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			fill_q <= '0;
			nbytes_q <= '0;
			wslot_q <= 1'b0;
			pad_first_q <= 1'b0;
			len_ok_q <= 1'b0;
		end else begin
			if (put) begin
				fill_q <= fill_q + 6'd1;
				if (fill_q == 6'd63) begin
					wslot_q <= !wslot_q;
				end
			end
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (data.has_byte) begin
							nbytes_q <= nbytes_q + 61'd1;
						end
						if (data.last_item) begin
							state_q <= F_PAD;
							pad_first_q <= 1'b1;
						end
					end
				end
				F_PAD: begin
					if (put) begin
						pad_first_q <= 1'b0;
						if (pad_first_q) begin
							len_ok_q <= (fill_q <= 6'd55) || (fill_q == 6'd63);
						end else if (fill_q == 6'd63) begin
							len_ok_q <= 1'b1;
						end
						if (final_put) begin
							state_q <= F_IDLE;
							nbytes_q <= '0;
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (put) begin
			acc_q <= {acc_q[15:0], put_byte};
		end
	end

endmodule
`default_nettype wire

@@ hdl/sha1e_back.sv @@
// Back part: loads queued blocks, runs the 80 SHA-1 rounds and holds the digest for output.
`default_nettype none
`include "assert_macros.svh"
module sha1e_back import sha1e_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        blk_ready,
	input  wire logic        blk_final,
	input  wire logic [31:0] rd_data,
	output qrd_t             qrd,
	input  wire logic        pop,
	output logic             empty,
	output out_item_t        result
);

	typedef enum logic [3:0] {
		B_IDLE  = 4'b0001,
		B_LOAD  = 4'b0010,
		B_ROUND = 4'b0100,
		B_ADD   = 4'b1000
	} bstate_t;

	bstate_t     state_q;
	logic [6:0]  cnt_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [5];
	logic [31:0] chain_q [5];
	logic [31:0] dig_q [5];
	logic [2:0]  oidx_q;
	logic        ovalid_q;
	logic        rslot_q;
	logic        fin_q;

	logic [31:0] f_w;
	logic [31:0] k_w;
	logic [31:0] tmp_w;
	logic [31:0] wnew_w;
	logic [31:0] wx_w;
	logic [31:0] sum_w [5];
	logic        start;
	logic        load_end;

	assign start = (state_q == B_IDLE) && blk_ready;
	assign load_end = (state_q == B_LOAD) && (cnt_q == 7'd16);

	always_comb begin
		qrd.start = start;
		qrd.release_blk = load_end;
		qrd.rd_addr = {rslot_q, cnt_q[3:0]};
		qrd.rd_slot = rslot_q;
	end

	always_comb begin
		priority if (cnt_q < 7'd20) begin
			f_w = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			k_w = K0;
		end else if (cnt_q < 7'd40) begin
			f_w = v_q[1] ^ v_q[2] ^ v_q[3];
			k_w = K1;
		end else if (cnt_q < 7'd60) begin
			f_w = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
			k_w = K2;
		end else begin
			f_w = v_q[1] ^ v_q[2] ^ v_q[3];
			k_w = K3;
		end
	end

	assign tmp_w = {v_q[0][26:0], v_q[0][31:27]} + f_w + v_q[4] + k_w + w_q[0];
	assign wx_w = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign wnew_w = {wx_w[30:0], wx_w[31]};

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			sum_w[i] = chain_q[i] + v_q[i];
		end
	end

	assign empty = !ovalid_q;
	always_comb begin
		result.digest_word = dig_q[0];
		result.word_index = oidx_q;
		result.last_word = (oidx_q == 3'd4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q <= '0;
			rslot_q <= 1'b0;
			fin_q <= 1'b0;
			ovalid_q <= 1'b0;
			oidx_q <= '0;
			chain_q[0] <= H0;
			chain_q[1] <= H1;
			chain_q[2] <= H2;
			chain_q[3] <= H3;
			chain_q[4] <= H4;
		end else begin
			if (pop && ovalid_q) begin
				if (oidx_q == 3'd4) begin
					ovalid_q <= 1'b0;
				end else begin
					oidx_q <= oidx_q + 3'd1;
				end
			end
			unique case (state_q)
				B_IDLE: begin
					if (blk_ready) begin
						state_q <= B_LOAD;
						cnt_q <= '0;
						fin_q <= blk_final;
					end
				end
				B_LOAD: begin
					if (cnt_q == 7'd16) begin
						state_q <= B_ROUND;
						cnt_q <= '0;
						rslot_q <= !rslot_q;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				B_ROUND: begin
					if (cnt_q == 7'd79) begin
						state_q <= B_ADD;
					end
					cnt_q <= cnt_q + 7'd1;
				end
				B_ADD: begin
					if (!fin_q) begin
						for (int i = 0; i < 5; i++) begin
							chain_q[i] <= sum_w[i];
						end
						state_q <= B_IDLE;
					end else if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						oidx_q <= '0;
						chain_q[0] <= H0;
						chain_q[1] <= H1;
						chain_q[2] <= H2;
						chain_q[3] <= H3;
						chain_q[4] <= H4;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_LOAD && cnt_q != 7'd0) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= rd_data;
		end else if (state_q == B_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wnew_w;
		end
		if (load_end) begin
			for (int i = 0; i < 5; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (state_q == B_ROUND) begin
			v_q[0] <= tmp_w;
			v_q[1] <= v_q[0];
			v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3];
		end
		if (state_q == B_ADD && fin_q && !ovalid_q) begin
			for (int i = 0; i < 5; i++) begin
				dig_q[i] <= sum_w[i];
			end
		end else if (pop && ovalid_q) begin
			for (int i = 0; i < 4; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
		end
	end

	`AST_SAME(a_round_cnt, clk, arst_n, state_q == B_ROUND, cnt_q < 7'd80, "round count out of range")
	`AST_NEXT(a_load_to_round, clk, arst_n, load_end, state_q == B_ROUND && cnt_q == 7'd0, "load did not enter rounds")
	`AST_SAME(a_out_idx, clk, arst_n, ovalid_q, oidx_q <= 3'd4, "digest index out of range")

endmodule
`default_nettype wire

@@ hdl/sha1_hash_engine.sv @@
// SHA-1 engine top level: the front part, the two-block word queue and the back part.
// Message bytes are taken one per cycle while the two-block queue has room and no padding
// is in progress. For each 64-byte block the back part takes a start step, loads the 16
// words through the registered queue read, runs the 80 rounds and does the chaining add;
// for a long message the round loop sets the rate. An item with the end mark is followed
// by padding, one byte per cycle while the queue has room, and the five digest words
// appear once the last one or two blocks are compressed. One digest is held while the next
// message streams in.
`default_nettype none
`include "assert_macros.svh"
module sha1_hash_engine import sha1e_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t data,
	input  wire logic     pop,
	output logic          empty,
	output out_item_t     result
);

	qwr_t        qwr;
	qrd_t        qrd;
	logic [31:0] rd_data;
	logic [5:0]  occ_q;
	logic [1:0]  ready_q;
	logic        fin_q [2];
	logic        space;

	assign space = (occ_q < 6'd32);

	sha1e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.data   (data),
		.space  (space),
		.qwr    (qwr)
	);

	sha1e_ram #(
		.Width (32),
		.Depth (QDepth)
	) u_queue (
		.clk   (clk),
		.we    (qwr.we),
		.waddr (qwr.addr),
		.wdata (qwr.data),
		.raddr (qrd.rd_addr),
		.rdata (rd_data)
	);

	sha1e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_ready (ready_q != 2'd0),
		.blk_final (fin_q[qrd.rd_slot]),
		.rd_data   (rd_data),
		.qrd       (qrd),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			ready_q <= '0;
			fin_q[0] <= 1'b0;
			fin_q[1] <= 1'b0;
		end else begin
			occ_q <= occ_q + {5'd0, qwr.we} - (qrd.release_blk ? 6'd16 : 6'd0);
			ready_q <= ready_q + {1'b0, qwr.block_done} - {1'b0, qrd.start};
			if (qwr.block_done) begin
				fin_q[qwr.addr[QAw-1]] <= qwr.final_blk;
			end
		end
	end

	`AST_SAME(a_occ, clk, arst_n, 1'b1, occ_q <= 6'd32, "queue occupancy above capacity")
	`AST_SAME(a_ready, clk, arst_n, 1'b1, ready_q <= 2'd2, "more than two blocks ready")
	`AST_SAME(a_start, clk, arst_n, qrd.start, ready_q != 2'd0, "block started with none ready")

endmodule
`default_nettype wire

@@ tb/tb_sha1_hash_engine.sv @@
// Testbench for the streaming SHA-1 engine: random messages checked against a SHA-1 predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_sha1_hash_engine;
	import sha1e_pkg::*;

	class digest_board;
		logic [31:0] chain [5];
		logic [31:0] blk [16];
		int unsigned fill;
		logic [60:0] nbytes;
		out_item_t pending [$];
		int errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
			fill = 0;
			nbytes = '0;
		endfunction

		function void compress();
			logic [31:0] w [80];
			logic [31:0] a, b, c, d, e, f, k, t;
			for (int i = 0; i < 16; i++) w[i] = blk[i];
			for (int i = 16; i < 80; i++) begin
				t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
				w[i] = {t[30:0], t[31]};
			end
			a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
			for (int i = 0; i < 80; i++) begin
				if (i < 20) begin
					f = (b & c) | (~b & d); k = K0;
				end else if (i < 40) begin
					f = b ^ c ^ d; k = K1;
				end else if (i < 60) begin
					f = (b & c) | (b & d) | (c & d); k = K2;
				end else begin
					f = b ^ c ^ d; k = K3;
				end
				t = {a[26:0], a[31:27]} + f + e + k + w[i];
				e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
			end
			chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
		endfunction

		function void pack_byte(logic [7:0] v);
			if (fill % 4 == 0)
				blk[fill / 4] = '0;
			blk[fill / 4][(3 - fill % 4) * 8 +: 8] = v;
			fill++;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		endfunction

		function void note_item(in_item_t it);
			logic [63:0] bits;
			out_item_t r;
			if (it.has_byte) begin
				pack_byte(it.data_byte);
				nbytes++;
			end
			if (!it.last_item)
				return;
			bits = {nbytes, 3'b000};
			pack_byte(PadByte);
			while (fill != 56)
				pack_byte(8'h00);
			for (int i = 7; i >= 0; i--)
				pack_byte(bits[i * 8 +: 8]);
			for (int i = 0; i < 5; i++) begin
				r.digest_word = chain[i];
				r.word_index = 3'(i);
				r.last_word = (i == 4);
				pending.push_back(r);
			end
			restart();
		endfunction

		function void check_word(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$error("unexpected digest word %h", got.digest_word);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.digest_word !== want.digest_word) begin
				$error("digest_word expected %h actual %h", want.digest_word, got.digest_word);
				errors++;
			end
			if (got.word_index !== want.word_index) begin
				$error("word_index expected %0d actual %0d", want.word_index, got.word_index);
				errors++;
			end
			if (got.last_word !== want.last_word) begin
				$error("last_word expected %0d actual %0d", want.last_word, got.last_word);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, push, pop, full, empty;
	in_item_t data;
	out_item_t result;
	digest_board board;
	bit hold_pop;
	bit stim_done;

	sha1_hash_engine u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .data(data),
		.pop(pop), .empty(empty), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_item(logic [7:0] b, logic hb, logic li);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data <= '{data_byte: b, has_byte: hb, last_item: li};
		do @(posedge clk); while (full);
		board.note_item(data);
	endtask

	task automatic send_message(int len, bit end_with_byte);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			if (end_with_byte && i == len - 1)
				send_item(8'($urandom), 1'b1, 1'b1);
			else
				send_item(8'($urandom), 1'b1, 1'b0);
		end
		if (!end_with_byte || len == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int lens [6];
		board = new();
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		data = '0;
		hold_pop = 1'b0;
		stim_done = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		lens = '{55, 56, 63, 64, 1, 3};
		foreach (lens[i])
			send_message(lens[i], i[0]);
		wait_drained();
		hold_pop = 1'b1;
		send_message(3, 1'b0);
		send_message(4, 1'b1);
		send_message(140, 1'b0);
		wait_drained();
		repeat (2)
			send_message($urandom_range(0, 10) == 0 ? $urandom_range(60, 130)
				: $urandom_range(0, 40), 1'($urandom_range(0, 1)));
		wait_drained();
		repeat (200) @(posedge clk);
		stim_done = 1'b1;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_pop) begin
				pop <= 1'b0;
				repeat (1500) @(posedge clk);
				hold_pop = 1'b0;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty && !hold_pop);
			if (!empty)
				board.check_word(result);
		end
	end

	initial begin
		wait (stim_done);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

@@ sha1_hash_engine.f @@
+incdir+hdl
hdl/sha1e_pkg.sv
hdl/sha1e_ram.sv
hdl/sha1e_front.sv
hdl/sha1e_back.sv
hdl/sha1_hash_engine.sv
tb/tb_sha1_hash_engine.sv
